// File: rtl/rsu_pkg.sv
// shared types, micro-operation codes, error codes and configuration register indices for the running statistics block
package rsu_pkg;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE        = 5'd0;
    localparam op_t OP_LOAD        = 5'd1;
    localparam op_t OP_CHECK       = 5'd2;
    localparam op_t OP_SQ_MEAN     = 5'd3;
    localparam op_t OP_SQ_DEV      = 5'd4;
    localparam op_t OP_SUM         = 5'd5;
    localparam op_t OP_MUL_STEP    = 5'd6;
    localparam op_t OP_DIVQ_SETUP  = 5'd7;
    localparam op_t OP_DIV_STEP    = 5'd8;
    localparam op_t OP_RMS_SETUP   = 5'd9;
    localparam op_t OP_SQRT_STEP   = 5'd10;
    localparam op_t OP_RMS         = 5'd11;
    localparam op_t OP_MEAN_SETUP  = 5'd12;
    localparam op_t OP_MEAN        = 5'd13;
    localparam op_t OP_MSQ         = 5'd14;
    localparam op_t OP_DEV         = 5'd15;
    localparam op_t OP_NS          = 5'd16;
    localparam op_t OP_DEN         = 5'd17;
    localparam op_t OP_HMUL_SETUP  = 5'd18;
    localparam op_t OP_HDIV_SETUP  = 5'd19;
    localparam op_t OP_HARM        = 5'd20;
    localparam op_t OP_OUT         = 5'd21;

    typedef logic [1:0] err_t;

    localparam err_t ERR_NONE  = 2'd0;
    localparam err_t ERR_ZERO  = 2'd1;
    localparam err_t ERR_COUNT = 2'd2;

    localparam logic [1:0] REG_COUNT     = 2'd0;
    localparam logic [1:0] REG_MEAN      = 2'd1;
    localparam logic [1:0] REG_HARMONIC  = 2'd2;
    localparam logic [1:0] REG_DEVIATION = 2'd3;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic zero_sample;
        logic count_max;
        logic q_lt_msq;
        logic den_zero;
    } status_t;

endpackage

// File: rtl/rsu_ctrl.sv
// sequencer that steps the datapath through one statistics update
module rsu_ctrl
    import rsu_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int W   = 2 * ((67 + COUNT_BITS) / 2);
    localparam int R   = W / 2;
    localparam int CNT = $clog2(W + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_SQA   = 5'd2;
    localparam logic [4:0] S_SQD   = 5'd3;
    localparam logic [4:0] S_SUM   = 5'd4;
    localparam logic [4:0] S_MULN  = 5'd5;
    localparam logic [4:0] S_ADDS  = 5'd6;
    localparam logic [4:0] S_DIVQ  = 5'd7;
    localparam logic [4:0] S_SQ1   = 5'd8;
    localparam logic [4:0] S_SQRT1 = 5'd9;
    localparam logic [4:0] S_RMS   = 5'd10;
    localparam logic [4:0] S_MEANP = 5'd11;
    localparam logic [4:0] S_DIVM  = 5'd12;
    localparam logic [4:0] S_MEAN  = 5'd13;
    localparam logic [4:0] S_MSQ   = 5'd14;
    localparam logic [4:0] S_SQRT2 = 5'd15;
    localparam logic [4:0] S_DEV   = 5'd16;
    localparam logic [4:0] S_NS    = 5'd17;
    localparam logic [4:0] S_DEN   = 5'd18;
    localparam logic [4:0] S_HP    = 5'd19;
    localparam logic [4:0] S_MULN1 = 5'd20;
    localparam logic [4:0] S_HSET  = 5'd21;
    localparam logic [4:0] S_DIVH  = 5'd22;
    localparam logic [4:0] S_HARM  = 5'd23;
    localparam logic [4:0] S_OUT   = 5'd24;

    localparam logic [CNT-1:0] CB_LAST = CNT'(COUNT_BITS - 1);
    localparam logic [CNT-1:0] W_LAST  = CNT'(W - 1);
    localparam logic [CNT-1:0] R_LAST  = CNT'(R - 1);

    logic [4:0]     state_reg, state_next;
    logic [CNT-1:0] cnt_reg, cnt_next;
    logic           valid_reg, valid_next;
    logic           cnt_done;
    logic           out_free;

    assign cnt_done  = (cnt_reg == '0);
    assign out_free  = !valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !out_ready;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.op = OP_CHECK;
                if (status.zero_sample || status.count_max)
                    state_next = S_OUT;
                else
                    state_next = S_SQA;
            end
            S_SQA:
            begin
                cmd.op     = OP_SQ_MEAN;
                state_next = S_SQD;
            end
            S_SQD:
            begin
                cmd.op     = OP_SQ_DEV;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                cnt_next   = CB_LAST;
                state_next = S_MULN;
            end
            S_MULN:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_ADDS;
            end
            S_ADDS:
            begin
                cmd.op     = OP_DIVQ_SETUP;
                cnt_next   = W_LAST;
                state_next = S_DIVQ;
            end
            S_DIVQ:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.op     = OP_RMS_SETUP;
                cnt_next   = R_LAST;
                state_next = S_SQRT1;
            end
            S_SQRT1:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_RMS;
            end
            S_RMS:
            begin
                cmd.op     = OP_RMS;
                state_next = S_MEANP;
            end
            S_MEANP:
            begin
                cmd.op     = OP_MEAN_SETUP;
                cnt_next   = W_LAST;
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_MEAN;
            end
            S_MEAN:
            begin
                cmd.op     = OP_MEAN;
                state_next = S_MSQ;
            end
            S_MSQ:
            begin
                cmd.op = OP_MSQ;
                if (status.q_lt_msq)
                    state_next = S_NS;
                else
                begin
                    cnt_next   = R_LAST;
                    state_next = S_SQRT2;
                end
            end
            S_SQRT2:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_DEV;
            end
            S_DEV:
            begin
                cmd.op     = OP_DEV;
                state_next = S_NS;
            end
            S_NS:
            begin
                cmd.op     = OP_NS;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                cmd.op     = OP_DEN;
                state_next = S_HP;
            end
            S_HP:
            begin
                cmd.op     = OP_HMUL_SETUP;
                cnt_next   = CB_LAST;
                state_next = S_MULN1;
            end
            S_MULN1:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_HSET;
            end
            S_HSET:
            begin
                cmd.op = OP_HDIV_SETUP;
                if (status.den_zero)
                    state_next = S_OUT;
                else
                begin
                    cnt_next   = W_LAST;
                    state_next = S_DIVH;
                end
            end
            S_DIVH:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_done)
                    state_next = S_HARM;
            end
            S_HARM:
            begin
                cmd.op     = OP_HARM;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: rtl/rsu_datapath.sv
// state, configuration registers, multiplier, shift-add, divide and square root datapath
module rsu_datapath
    import rsu_pkg::*;
#(
    parameter int COUNT_BITS    = 20,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [31:0]           sample,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic [COUNT_BITS-1:0] value_count,
    output logic [31:0]           std_deviation,
    output logic [31:0]           arith_mean,
    output logic [31:0]           root_mean_square,
    output logic [31:0]           harm_mean,
    output err_t                  error_code
);

    localparam int W  = 2 * ((67 + COUNT_BITS) / 2);
    localparam int R  = W / 2;
    localparam int DW = 66;
    localparam int CB = COUNT_BITS;

    localparam logic [31:0] UNITY = 32'(64'd1 << FRACTION_BITS);

    logic [CB-1:0] init_count_reg, init_count_next;
    logic [31:0]   init_mean_reg, init_mean_next;
    logic [31:0]   init_harm_reg, init_harm_next;
    logic [31:0]   init_dev_reg, init_dev_next;

    logic [CB-1:0] count_reg;
    logic [31:0]   mean_reg, harmonic_reg, deviation_reg;

    logic [31:0]   s_reg;
    logic [63:0]   p_reg;
    logic [W-1:0]  t_reg, m_reg, x_reg, q_reg;
    logic [CB-1:0] f_reg;
    logic [DW-1:0] d_reg, rem_reg;
    logic [R-1:0]  root_reg;
    logic [31:0]   rms_new_reg, mean_new_reg, dev_new_reg, harm_new_reg;
    err_t          err_reg;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [CB:0]   n1;
    logic [31:0]   x_sat, root_sat;

    logic [DW:0]   div_ext, div_dz, div_diff;
    logic          div_ge;
    logic [DW+1:0] sq_ext, sq_trial, sq_diff;
    logic          sq_ge;

    function automatic logic [31:0] sat_w(input logic [W-1:0] v);
        sat_w = (|v[W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    assign n1       = {1'b0, count_reg} + 1'b1;
    assign x_sat    = sat_w(x_reg);
    assign root_sat = sat_w(W'(root_reg));

    assign div_ext  = {rem_reg, x_reg[W-1]};
    assign div_dz   = {1'b0, d_reg};
    assign div_ge   = (div_ext >= div_dz);
    assign div_diff = div_ext - div_dz;

    assign sq_ext   = {rem_reg, x_reg[W-1:W-2]};
    assign sq_trial = (DW+2)'({root_reg, 2'b01});
    assign sq_ge    = (sq_ext >= sq_trial);
    assign sq_diff  = sq_ext - sq_trial;

    assign status.zero_sample = (s_reg == '0);
    assign status.count_max   = (count_reg == '1);
    assign status.q_lt_msq    = (q_reg < W'(p_reg));
    assign status.den_zero    = (d_reg == '0);

    // operand select for the shared 32x32 multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQ_MEAN:
            begin
                mul_a = mean_reg;
                mul_b = mean_reg;
            end
            OP_SQ_DEV:
            begin
                mul_a = deviation_reg;
                mul_b = deviation_reg;
            end
            OP_SUM:
            begin
                mul_a = s_reg;
                mul_b = s_reg;
            end
            OP_RMS:
            begin
                mul_a = 32'(count_reg);
                mul_b = mean_reg;
            end
            OP_MEAN:
            begin
                mul_a = x_sat;
                mul_b = x_sat;
            end
            OP_NS:
            begin
                mul_a = 32'(count_reg);
                mul_b = s_reg;
            end
            OP_DEN:
            begin
                mul_a = s_reg;
                mul_b = harmonic_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        init_count_next = init_count_reg;
        init_mean_next  = init_mean_reg;
        init_harm_next  = init_harm_reg;
        init_dev_next   = init_dev_reg;
        case (cfg_index)
            REG_COUNT:     init_count_next = cfg_data[CB-1:0];
            REG_MEAN:      init_mean_next  = cfg_data;
            REG_HARMONIC:  init_harm_next  = cfg_data;
            REG_DEVIATION: init_dev_next   = cfg_data;
            default:       init_count_next = init_count_reg;
        endcase
    end

    // configuration and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_count_reg <= CB'(1);
            init_mean_reg  <= UNITY;
            init_harm_reg  <= UNITY;
            init_dev_reg   <= UNITY;
            count_reg      <= CB'(1);
            mean_reg       <= UNITY;
            harmonic_reg   <= UNITY;
            deviation_reg  <= UNITY;
        end
        else if (cfg_write)
        begin
            init_count_reg <= init_count_next;
            init_mean_reg  <= init_mean_next;
            init_harm_reg  <= init_harm_next;
            init_dev_reg   <= init_dev_next;
            count_reg      <= init_count_next;
            mean_reg       <= init_mean_next;
            harmonic_reg   <= init_harm_next;
            deviation_reg  <= init_dev_next;
        end
        else if (cmd.op == OP_OUT && err_reg == ERR_NONE)
        begin
            count_reg     <= n1[CB-1:0];
            mean_reg      <= mean_new_reg;
            harmonic_reg  <= harm_new_reg;
            deviation_reg <= dev_new_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                s_reg <= sample;
            end
            OP_CHECK:
            begin
                if (status.zero_sample)
                    err_reg <= ERR_ZERO;
                else if (status.count_max)
                    err_reg <= ERR_COUNT;
                else
                    err_reg <= ERR_NONE;
            end
            OP_SQ_MEAN:
            begin
                p_reg <= mul_p;
            end
            OP_SQ_DEV:
            begin
                t_reg <= W'(p_reg);
                p_reg <= mul_p;
            end
            OP_SUM:
            begin
                m_reg <= t_reg + W'(p_reg);
                f_reg <= count_reg;
                t_reg <= '0;
                p_reg <= mul_p;
            end
            OP_MUL_STEP:
            begin
                if (f_reg[0])
                    t_reg <= t_reg + m_reg;
                m_reg <= {m_reg[W-2:0], 1'b0};
                f_reg <= f_reg >> 1;
            end
            OP_DIVQ_SETUP:
            begin
                x_reg   <= t_reg + W'(p_reg);
                d_reg   <= DW'(n1);
                rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? div_diff[DW-1:0] : div_ext[DW-1:0];
                x_reg   <= {x_reg[W-2:0], div_ge};
            end
            OP_RMS_SETUP:
            begin
                q_reg    <= x_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                rem_reg  <= sq_ge ? sq_diff[DW-1:0] : sq_ext[DW-1:0];
                root_reg <= {root_reg[R-2:0], sq_ge};
                x_reg    <= {x_reg[W-3:0], 2'b00};
            end
            OP_RMS:
            begin
                rms_new_reg <= root_sat;
                p_reg       <= mul_p;
            end
            OP_MEAN_SETUP:
            begin
                x_reg   <= W'(p_reg) + W'(s_reg);
                d_reg   <= DW'(n1);
                rem_reg <= '0;
            end
            OP_MEAN:
            begin
                mean_new_reg <= x_sat;
                p_reg        <= mul_p;
            end
            OP_MSQ:
            begin
                dev_new_reg <= '0;
                x_reg       <= q_reg - W'(p_reg);
                rem_reg     <= '0;
                root_reg    <= '0;
            end
            OP_DEV:
            begin
                dev_new_reg <= root_sat;
            end
            OP_NS:
            begin
                p_reg <= mul_p;
            end
            OP_DEN:
            begin
                d_reg <= DW'(harmonic_reg) + DW'(p_reg);
                p_reg <= mul_p;
            end
            OP_HMUL_SETUP:
            begin
                m_reg <= W'(p_reg);
                f_reg <= n1[CB-1:0];
                t_reg <= '0;
            end
            OP_HDIV_SETUP:
            begin
                harm_new_reg <= '0;
                x_reg        <= t_reg;
                rem_reg      <= '0;
            end
            OP_HARM:
            begin
                harm_new_reg <= x_sat;
            end
            OP_OUT:
            begin
                error_code <= err_reg;
                if (err_reg == ERR_NONE)
                begin
                    value_count      <= n1[CB-1:0];
                    std_deviation    <= dev_new_reg;
                    arith_mean       <= mean_new_reg;
                    root_mean_square <= rms_new_reg;
                    harm_mean        <= harm_new_reg;
                end
                else
                begin
                    value_count      <= count_reg;
                    std_deviation    <= deviation_reg;
                    arith_mean       <= mean_reg;
                    root_mean_square <= '0;
                    harm_mean        <= harmonic_reg;
                end
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase
    end

endmodule

// File: rtl/running_statistics_update.sv
// running count, mean, rms, harmonic mean and standard deviation update
// working width W = 86 at COUNT_BITS = 20; an update runs bit-serial divides (three) and two-bit-a-step
// roots (two), and the second root is skipped when the quotient is below the mean square
// one sample is handled at a time, and a rejected sample skips the arithmetic;
// the next sample is taken while the previous result waits in the output register
// reset: asynchronous active-low, state loads count 1 and 1.0 for mean, harmonic and deviation
module running_statistics_update
    import rsu_pkg::*;
#(
    parameter int COUNT_BITS    = 20,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,   // sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // value_count, std_deviation, arith_mean, root_mean_square, harm_mean, zero pad
    output logic [((COUNT_BITS+128+7)/8)*8-1:0]  m_tdata,
    output logic [1:0]                           m_tuser,   // error_code
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam int TDW = ((COUNT_BITS + 128 + 7) / 8) * 8;

    cmd_t                  cmd;
    status_t               status;
    logic [COUNT_BITS-1:0] value_count;
    logic [31:0]           std_deviation, arith_mean, root_mean_square, harm_mean;
    err_t                  error_code;

    assign cfg_ready = 1'b1;

    rsu_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rsu_datapath #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sample           (s_tdata),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .value_count      (value_count),
        .std_deviation    (std_deviation),
        .arith_mean       (arith_mean),
        .root_mean_square (root_mean_square),
        .harm_mean        (harm_mean),
        .error_code       (error_code)
    );

    assign m_tdata = TDW'({harm_mean, root_mean_square, arith_mean, std_deviation, value_count});
    assign m_tuser = error_code;

endmodule
